>>> rtl/bptc_pkg.sv
// Package: shared types and constants for the barometric compensation pipeline.
`default_nettype none
package bptc_pkg;

  localparam int unsigned NumRegs = 5;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC5_AC6 = 3'd0,
    REG_MC_MD   = 3'd1,
    REG_AC1_AC2 = 3'd2,
    REG_AC3_AC4 = 3'd3,
    REG_B1_B2   = 3'd4
  } reg_idx_e;

  localparam logic [31:0] C4000  = 32'd4000;
  localparam logic [31:0] C32768 = 32'd32768;
  localparam logic [31:0] C50000 = 32'd50000;
  localparam logic [31:0] C3038  = 32'd3038;
  localparam logic [31:0] CM7357 = 32'hFFFF_E343;
  localparam logic [31:0] C3791  = 32'd3791;

  // Unsigned divide pipeline width and number of quotient bits per stage
  localparam int unsigned DivW    = 32;
  localparam int unsigned DivBits = 2;
  localparam int unsigned DivStg  = DivW / DivBits;

  // Signed divide sideband: sign of quotient, error, plus carried payload
  typedef struct packed {
    logic        neg;
    logic        err;
    logic [31:0] x1;
    logic [15:0] up;
  } tdiv_side_t;

  typedef struct packed {
    logic        err;
    logic [31:0] t;
    logic        hi;
  } pdiv_side_t;

  function automatic logic [31:0] asr(input logic [31:0] u, input int unsigned n);
    asr = 32'($signed(u) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

>>> rtl/bptc_udiv.sv
// Module: pipelined unsigned 32-bit divider, two quotient bits per stage, with sideband.
`default_nettype none
module bptc_udiv #(
  parameter int unsigned SideW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [31:0]      num_i,
  input  wire logic [31:0]      den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [31:0]           quo_o,
  output logic [SideW-1:0]      side_o
);
  localparam int unsigned S = bptc_pkg::DivStg;
  localparam int unsigned B = bptc_pkg::DivBits;

  logic [S:0]            vld_q;
  logic [31:0]           rem_q  [S+1];
  logic [31:0]           num_q  [S+1];
  logic [31:0]           den_q  [S+1];
  logic [SideW-1:0]      side_q [S+1];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = '0;
  assign num_q[0]  = num_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  // One radix-4 restoring step per stage; quotient shifts into num
  for (genvar g = 0; g < S; g++) begin : g_stg
    logic [32:0] r;
    logic [31:0] n;
    always_comb begin
      r = {1'b0, rem_q[g]};
      n = num_q[g];
      for (int k = 0; k < B; k++) begin
        r = {r[31:0], n[31]};
        n = {n[30:0], 1'b0};
        if (r >= {1'b0, den_q[g]}) begin
          r    = r - {1'b0, den_q[g]};
          n[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= r[31:0];
        num_q[g+1]  <= n;
        den_q[g+1]  <= den_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = vld_q[S];
  assign quo_o   = num_q[S];
  assign side_o  = side_q[S];
endmodule
`default_nettype wire

>>> rtl/baro_pressure_temp_compensation.sv
// Top level: pipelined integer temperature and pressure compensation with two dividers.
// Stages: 2*16 divider stages plus 9 arithmetic stages from input to output.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline (no loss).
// Reset: asynchronous active low; calibration registers and all valid bits clear to zero.
// Zero divisors set div_error and force both results to zero.
`default_nettype none
module baro_pressure_temp_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // raw_temp[15:0], raw_press[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata    // temp_tenths_c, press_pa, div_error, zero pad
);
  logic [31:0] cal_q [bptc_pkg::NumRegs];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bptc_pkg::NumRegs; i++) cal_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bptc_pkg::REG_AC5_AC6: cal_q[bptc_pkg::REG_AC5_AC6] <= cfg_data_i;
        bptc_pkg::REG_MC_MD:   cal_q[bptc_pkg::REG_MC_MD]   <= cfg_data_i;
        bptc_pkg::REG_AC1_AC2: cal_q[bptc_pkg::REG_AC1_AC2] <= cfg_data_i;
        bptc_pkg::REG_AC3_AC4: cal_q[bptc_pkg::REG_AC3_AC4] <= cfg_data_i;
        bptc_pkg::REG_B1_B2:   cal_q[bptc_pkg::REG_B1_B2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
  assign ac5 = {16'd0, cal_q[bptc_pkg::REG_AC5_AC6][31:16]};
  assign ac6 = {16'd0, cal_q[bptc_pkg::REG_AC5_AC6][15:0]};
  assign mc  = bptc_pkg::sx16(cal_q[bptc_pkg::REG_MC_MD][31:16]);
  assign md  = bptc_pkg::sx16(cal_q[bptc_pkg::REG_MC_MD][15:0]);
  assign ac1 = bptc_pkg::sx16(cal_q[bptc_pkg::REG_AC1_AC2][31:16]);
  assign ac2 = bptc_pkg::sx16(cal_q[bptc_pkg::REG_AC1_AC2][15:0]);
  assign ac3 = bptc_pkg::sx16(cal_q[bptc_pkg::REG_AC3_AC4][31:16]);
  assign ac4 = {16'd0, cal_q[bptc_pkg::REG_AC3_AC4][15:0]};
  assign b1  = bptc_pkg::sx16(cal_q[bptc_pkg::REG_B1_B2][31:16]);
  assign b2  = bptc_pkg::sx16(cal_q[bptc_pkg::REG_B1_B2][15:0]);

  // Global stall: the output register is the only hold point
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: X1 product
  logic        a_vld_q;
  logic [31:0] a_prod_q;
  logic [15:0] a_up_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q <= ({16'd0, s_axis_tdata[15:0]} - ac6) * ac5;
      a_up_q   <= s_axis_tdata[31:16];
    end
  end

  // Stage B: X1, divisor, sign handling for truncating divide
  logic [31:0] bx1, bden, bnum;
  assign bx1  = bptc_pkg::asr(a_prod_q, 15);
  assign bden = bx1 + md;
  assign bnum = mc << 11;
  bptc_pkg::tdiv_side_t td_in, td_out;
  assign td_in.neg = bnum[31] ^ bden[31];
  assign td_in.err = (bden == '0);
  assign td_in.x1  = bx1;
  assign td_in.up  = a_up_q;
  logic        td_vld;
  logic [31:0] td_quo;
  bptc_udiv #(.SideW($bits(bptc_pkg::tdiv_side_t))) u_tdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q),
    .num_i(bnum[31] ? -bnum : bnum),
    .den_i(bden[31] ? -bden : bden),
    .side_i(td_in), .valid_o(td_vld), .quo_o(td_quo), .side_o(td_out)
  );

  // Stage C: B5, T, B6
  logic        c_vld_q, c_err_q;
  logic [31:0] c_t_q, c_b6_q;
  logic [15:0] c_up_q;
  logic [31:0] cx2, cb5;
  assign cx2 = td_out.neg ? -td_quo : td_quo;
  assign cb5 = td_out.x1 + cx2;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= td_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_err_q <= td_out.err;
      c_t_q   <= bptc_pkg::asr(cb5 + 32'd8, 4);
      c_b6_q  <= cb5 - bptc_pkg::C4000;
      c_up_q  <= td_out.up;
    end
  end

  // Stage D: B6 squared and linear products
  logic        d_vld_q, d_err_q;
  logic [31:0] d_t_q, d_sqp_q, d_ac2_q, d_ac3_q;
  logic [15:0] d_up_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_err_q <= c_err_q;
      d_t_q   <= c_t_q;
      d_sqp_q <= c_b6_q * c_b6_q;
      d_ac2_q <= ac2 * c_b6_q;
      d_ac3_q <= ac3 * c_b6_q;
      d_up_q  <= c_up_q;
    end
  end

  // Stage E: products with SQ, X3 parts
  logic        e_vld_q, e_err_q;
  logic [31:0] e_t_q, e_b2_q, e_b1_q, e_ac2_q, e_ac3_q, esq;
  logic [15:0] e_up_q;
  assign esq = bptc_pkg::asr(d_sqp_q, 12);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= d_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_err_q <= d_err_q;
      e_t_q   <= d_t_q;
      e_b2_q  <= b2 * esq;
      e_b1_q  <= b1 * esq;
      e_ac2_q <= d_ac2_q;
      e_ac3_q <= d_ac3_q;
      e_up_q  <= d_up_q;
    end
  end

  // Stage F: B3 and X3 for B4
  logic        f_vld_q, f_err_q;
  logic [31:0] f_t_q, f_b3_q, f_x3_q;
  logic [15:0] f_up_q;
  logic [31:0] fx3a, fx3b;
  assign fx3a = bptc_pkg::asr(e_b2_q, 11) + bptc_pkg::asr(e_ac2_q, 11);
  assign fx3b = bptc_pkg::asr(bptc_pkg::asr(e_ac3_q, 13) + bptc_pkg::asr(e_b1_q, 16)
                + 32'd2, 2);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_err_q <= e_err_q;
      f_t_q   <= e_t_q;
      f_b3_q  <= bptc_pkg::asr((ac1 << 2) + fx3a + 32'd2, 2);
      f_x3_q  <= fx3b;
      f_up_q  <= e_up_q;
    end
  end

  // Stage G: B4 and B7 products
  logic        g_vld_q, g_err_q;
  logic [31:0] g_t_q, g_b4p_q, g_b7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= f_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_err_q <= f_err_q;
      g_t_q   <= f_t_q;
      g_b4p_q <= ac4 * (f_x3_q + bptc_pkg::C32768);
      g_b7_q  <= ({16'd0, f_up_q} - f_b3_q) * bptc_pkg::C50000;
    end
  end

  // Pressure divide with the B7 split
  logic [31:0] gb4;
  assign gb4 = g_b4p_q >> 15;
  bptc_pkg::pdiv_side_t pd_in, pd_out;
  assign pd_in.err = g_err_q || (gb4 == '0);
  assign pd_in.t   = g_t_q;
  assign pd_in.hi  = g_b7_q[31];
  logic        pd_vld;
  logic [31:0] pd_quo;
  bptc_udiv #(.SideW($bits(bptc_pkg::pdiv_side_t))) u_pdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_vld_q),
    .num_i(g_b7_q[31] ? g_b7_q : (g_b7_q << 1)), .den_i(gb4),
    .side_i(pd_in), .valid_o(pd_vld), .quo_o(pd_quo), .side_o(pd_out)
  );

  // Stage H: P and correction products
  logic        h_vld_q, h_err_q;
  logic [31:0] h_t_q, h_p_q, h_sq_q, h_x2_q, hp, hp8;
  assign hp  = pd_out.hi ? (pd_quo << 1) : pd_quo;
  assign hp8 = bptc_pkg::asr(hp, 8);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= pd_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_err_q <= pd_out.err;
      h_t_q   <= pd_out.t;
      h_p_q   <= hp;
      h_sq_q  <= hp8 * hp8;
      h_x2_q  <= bptc_pkg::CM7357 * hp;
    end
  end

  // Stage I: X1 times 3038
  logic        i_vld_q, i_err_q;
  logic [31:0] i_t_q, i_p_q, i_x1_q, i_x2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_vld_q <= 1'b0;
    else if (en) i_vld_q <= h_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      i_err_q <= h_err_q;
      i_t_q   <= h_t_q;
      i_p_q   <= h_p_q;
      i_x1_q  <= h_sq_q * bptc_pkg::C3038;
      i_x2_q  <= bptc_pkg::asr(h_x2_q, 16);
    end
  end

  // Output register: final pressure sum
  logic [31:0] ofin;
  assign ofin = i_p_q + bptc_pkg::asr(bptc_pkg::asr(i_x1_q, 16) + i_x2_q
                + bptc_pkg::C3791, 4);
  logic [71:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= i_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {7'd0, i_err_q, i_err_q ? 32'd0 : ofin, i_err_q ? 32'd0 : i_t_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

>>> sim/baro_pressure_temp_compensation_tb.sv
// Testbench: barometric compensation checked against a built-in integer predictor.
`default_nettype none
module baro_pressure_temp_compensation_tb;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        err;
  } comp_res_t;

  // One directed row; load selects a calibration reload before the item
  typedef struct {
    bit          load;
    logic [31:0] c0, c1, c2, c3, c4;
    logic [15:0] ut;
    logic [15:0] up;
    logic        chk;
    comp_res_t   res;
  } stim_row_t;

  localparam int unsigned WatchLimit = 5000;

  // Typical sensor calibration set
  localparam logic [31:0] TypAc5Ac6 = {16'd32757, 16'd23153};
  localparam logic [31:0] TypMcMd   = {16'hD4BD, 16'd2868};
  localparam logic [31:0] TypAc1Ac2 = {16'd408, 16'hFFCA};
  localparam logic [31:0] TypAc3Ac4 = {16'hC158, 16'd32741};
  localparam logic [31:0] TypB1B2   = {16'd6190, 16'd4};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  logic [31:0] cal_q [bptc_pkg::NumRegs];
  comp_res_t   exp_res_q [$];
  int unsigned err_cnt = 0;
  int unsigned idle_cyc = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  baro_pressure_temp_compensation i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Fixed-point compensation with 32-bit wrap, truncating division, B7 split
  function automatic comp_res_t compensate(input logic [15:0] ut, input logic [15:0] up);
    logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
    logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, den, t, sq;
    comp_res_t   r;
    ac5 = {16'd0, cal_q[bptc_pkg::REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal_q[bptc_pkg::REG_AC5_AC6][15:0]};
    mc  = sext(cal_q[bptc_pkg::REG_MC_MD][31:16]);
    md  = sext(cal_q[bptc_pkg::REG_MC_MD][15:0]);
    ac1 = sext(cal_q[bptc_pkg::REG_AC1_AC2][31:16]);
    ac2 = sext(cal_q[bptc_pkg::REG_AC1_AC2][15:0]);
    ac3 = sext(cal_q[bptc_pkg::REG_AC3_AC4][31:16]);
    ac4 = {16'd0, cal_q[bptc_pkg::REG_AC3_AC4][15:0]};
    b1  = sext(cal_q[bptc_pkg::REG_B1_B2][31:16]);
    b2  = sext(cal_q[bptc_pkg::REG_B1_B2][15:0]);
    r = '{temp: '0, press: '0, err: 1'b1};
    x1 = sra(32'(({16'd0, ut} - ac6) * ac5), 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = 32'($signed(mc << 11) / $signed(den));
    b5 = x1 + x2;
    t = sra(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra(32'(b6 * b6), 12);
    x1 = sra(32'(b2 * sq), 11);
    x2 = sra(32'(ac2 * b6), 11);
    x3 = x1 + x2;
    b3 = sra(32'(ac1 * 32'd4) + x3 + 32'd2, 2);
    x1 = sra(32'(ac3 * b6), 13);
    x2 = sra(32'(b1 * sq), 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = 32'(ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = 32'(({16'd0, up} - b3) * 32'd50000);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = 32'(sra(p, 8) * sra(p, 8));
    x1 = sra(32'(x1 * 32'd3038), 16);
    x2 = sra(32'(32'hFFFF_E343 * p), 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    r = '{temp: t, press: p, err: 1'b0};
    return r;
  endfunction

  // One register write, after which the write enable is deasserted
  task automatic write_cal(input bptc_pkg::reg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cal_q[idx] = val;
    @(negedge clk_i);
  endtask

  // Stop offering items and wait until every result is out
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (exp_res_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // Send one item; expectation is pushed at the accepting edge
  task automatic send_item(input logic [15:0] ut, input logic [15:0] up, input bit gaps);
    int unsigned w;
    w = gaps ? $urandom_range(4) : 0;
    if (w != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {up, ut};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_res_q.push_back(compensate(ut, up));
    @(negedge clk_i);
  endtask

  task automatic load_cal(input logic [31:0] v0, v1, v2, v3, v4);
    write_cal(bptc_pkg::REG_AC5_AC6, v0);
    write_cal(bptc_pkg::REG_MC_MD, v1);
    write_cal(bptc_pkg::REG_AC1_AC2, v2);
    write_cal(bptc_pkg::REG_AC3_AC4, v3);
    write_cal(bptc_pkg::REG_B1_B2, v4);
  endtask

  task automatic load_typical();
    load_cal(TypAc5Ac6, TypMcMd, TypAc1Ac2, TypAc3Ac4, TypB1B2);
  endtask

  // Raw words near the typical operating point, with some full-range noise
  function automatic logic [15:0] pick_ut();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 15000));
  endfunction

  function automatic logic [15:0] pick_up();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40000, 15000));
  endfunction

  // Stimulus
  initial begin
    stim_row_t rows [$];
    comp_res_t zero_err;
    zero_err = '{temp: '0, press: '0, err: 1'b1};
    foreach (cal_q[i]) cal_q[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // After reset every divisor is zero: error with zero results
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h0000, 16'h0000, 1'b1, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b1, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h5555, 16'hAAAA, 1'b1, zero_err});
    // Typical calibration: the classic sample point and extremes
    rows.push_back('{1'b1, TypAc5Ac6, TypMcMd, TypAc1Ac2, TypAc3Ac4, TypB1B2,
                     16'd27898, 16'd23843, 1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h0000, 16'h0000, 1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h0000, 16'hFFFF, 1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'hFFFF, 16'h0000, 1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h8000, 16'h7FFF, 1'b0, zero_err});
    // Temperature divisor zero: AC5 = 0 gives X1 = 0, MD = 0
    rows.push_back('{1'b1, {16'd0, 16'd100}, {16'd5, 16'd0}, '0, {16'd0, 16'd1}, '0,
                     16'd1234, 16'd4321, 1'b1, zero_err});
    // Pressure divisor zero: AC4 = 0
    rows.push_back('{1'b1, {16'd1, 16'd0}, {16'd1, 16'd1}, 32'hFFFF_FFFF,
                     {16'hFFFF, 16'd0}, 32'hFFFF_FFFF, 16'd100, 16'd200, 1'b1, zero_err});
    // Extreme calibration words, wrapping arithmetic
    rows.push_back('{1'b1, 32'hFFFF_FFFF, {16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF},
                     {16'h7FFF, 16'hFFFF}, {16'h8000, 16'h8000}, 16'hFFFF, 16'h0000,
                     1'b0, zero_err});
    rows.push_back('{1'b0, '0, '0, '0, '0, '0, 16'h0000, 16'hFFFF, 1'b0, zero_err});
    foreach (rows[i]) begin
      if (rows[i].load) begin
        drain_wait();
        load_cal(rows[i].c0, rows[i].c1, rows[i].c2, rows[i].c3, rows[i].c4);
      end
      send_item(rows[i].ut, rows[i].up, 1'b0);
      if (rows[i].chk && compensate(rows[i].ut, rows[i].up) != rows[i].res)
        exp_res_q[$] = rows[i].res;
    end
    drain_wait();

    // Index above the register range is ignored
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'd7;
    cfg_data_i <= 32'hDEAD_BEEF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_item(16'd5000, 16'd6000, 1'b0);
    drain_wait();

    // Random phases, each reloading calibration: typical on even phases, random on odd
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) load_typical();
      else load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < 200; n++) begin
        // pause until everything has drained, once
        if (ph == 3 && n == 100) drain_wait();
        send_item(pick_ut(), pick_up(), (ph % 3) != 1);
      end
      drain_wait();
    end
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off while the pipe fills
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (120) @(negedge clk_i);
        hold_off = 1'b0;
      end
      w = ($urandom_range(7) < 2) ? 0 : $urandom_range(4);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Result check at each accepting edge
  always @(posedge clk_i) begin
    comp_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{temp: m_axis_tdata[31:0], press: m_axis_tdata[63:32], err: m_axis_tdata[64]};
      if (exp_res_q.size() == 0) begin
        $error("unexpected result temp=%0d press=%0d", $signed(got.temp),
               $signed(got.press));
        err_cnt++;
      end else begin
        want = exp_res_q.pop_front();
        if (got.temp !== want.temp) begin
          $error("temp_tenths_c exp %0d got %0d", $signed(want.temp), $signed(got.temp));
          err_cnt++;
        end
        if (got.press !== want.press) begin
          $error("press_pa exp %0d got %0d", $signed(want.press), $signed(got.press));
          err_cnt++;
        end
        if (got.err !== want.err) begin
          $error("div_error exp %0b got %0b", want.err, got.err);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake, and the final verdict
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WatchLimit) begin
      $display("baro_pressure_temp_compensation: mismatch");
      $finish;
    end else if (stim_done) begin
      if (err_cnt == 0 && exp_res_q.size() == 0)
        $display("baro_pressure_temp_compensation: match");
      else
        $display("baro_pressure_temp_compensation: mismatch");
      $finish;
    end
  end

endmodule
`default_nettype wire
